### rtl/apr_pkg.sv
// Shared constants and types for the accumulated pixel resolve block.
`default_nettype none
package apr_pkg;

  localparam int ACC_FRAC_BITS = 16;

  localparam int COORD_W = 12;
  localparam int SUM_W   = 32;
  localparam int PASS_W  = 16;
  localparam int DIV_W   = 17;
  localparam int CFG_W   = 13;
  localparam int OFF_W   = 26;
  localparam int CH_W    = 8;
  localparam int RHS_W   = 48;
  localparam int PROD_W  = CFG_W + COORD_W;
  localparam int IDX_W   = 3;

  localparam logic [15:0]    SCALE_SQ      = 16'd65025;
  localparam logic [CH_W-1:0] FULL_BYTE    = 8'd255;
  localparam logic [DIV_W-1:0] FINAL_DIVISOR = 17'd4;
  localparam logic [DIV_W-1:0] UNIT_DIVISOR  = 17'd1;
  localparam logic [COORD_W-1:0] BAR_ROWS  = 12'd3;
  localparam logic [CFG_W-1:0] RESET_WIDTH = 13'd640;

  // register map
  localparam logic [IDX_W-1:0] REG_INTERACTIVE = 3'd0;
  localparam logic [IDX_W-1:0] REG_PASSES      = 3'd1;
  localparam logic [IDX_W-1:0] REG_PROG_EN     = 3'd2;
  localparam logic [IDX_W-1:0] REG_PROG_COLS   = 3'd3;
  localparam logic [IDX_W-1:0] REG_WIDTH       = 3'd4;

  // root search steps, one per result bit
  localparam int STEPS = CH_W;

  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic             fin;
    logic             mark;
    logic             bar;
  } side_t;

endpackage
`default_nettype wire

### rtl/apr_lane.sv
// One color channel: scaled sum, then a bit-per-stage integer root search.
`default_nettype none
module apr_lane #(
  parameter int ACC_FRAC_BITS = apr_pkg::ACC_FRAC_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [apr_pkg::SUM_W-1:0]    sum,
  input  wire logic [apr_pkg::DIV_W-1:0]    div,
  output logic      [apr_pkg::CH_W-1:0]     kout
);

  localparam int W  = apr_pkg::RHS_W;
  localparam int N  = apr_pkg::STEPS;

  // per-stage state: k, D*k, D*k*k, limit, D
  logic [apr_pkg::CH_W-1:0]  k   [N+1];
  logic [W-1:0]              q   [N+1];
  logic [W-1:0]              p   [N+1];
  logic [W-1:0]              lim [N+1];
  logic [apr_pkg::DIV_W-1:0] d   [N+1];

  logic [W-1:0] rhs;
  assign rhs = W'(sum) * W'(apr_pkg::SCALE_SQ);

  // k*k*D*2^F <= rhs  <=>  k*k*D <= rhs >> F
  always_ff @(posedge clk) begin
    if (en) begin
      lim[0] <= rhs >> ACC_FRAC_BITS;
      d[0]   <= div;
      k[0]   <= '0;
      q[0]   <= '0;
      p[0]   <= '0;
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_step
    localparam int B = N - 1 - j;
    logic [W-1:0] trial;
    logic         take;
    // (k+2^B)^2*D = k^2*D + (D*k)<<(B+1) + D<<(2B)
    assign trial = p[j] + (q[j] << (B + 1)) + (W'(d[j]) << (2 * B));
    assign take  = trial <= lim[j];
    always_ff @(posedge clk) begin
      if (en) begin
        lim[j+1] <= lim[j];
        d[j+1]   <= d[j];
        if (take) begin
          k[j+1] <= k[j] | apr_pkg::CH_W'(1 << B);
          q[j+1] <= q[j] + (W'(d[j]) << B);
          p[j+1] <= trial;
        end else begin
          k[j+1] <= k[j];
          q[j+1] <= q[j];
          p[j+1] <= p[j];
        end
      end
    end
  end

  assign kout = k[N];

endmodule
`default_nettype wire

### rtl/apr_merge.sv
// Output stage: applies finalize marking and progress bar, holds the beat.
`default_nettype none
module apr_merge (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       adv,
  input  wire logic                       in_valid,
  input  wire apr_pkg::side_t             side,
  input  wire logic [apr_pkg::CH_W-1:0]   red_k,
  input  wire logic [apr_pkg::CH_W-1:0]   green_k,
  input  wire logic [apr_pkg::CH_W-1:0]   blue_k,
  output logic                            m_tvalid,
  output logic [55:0]                     m_tdata,
  output logic [0:0]                      m_tuser
);

  logic [apr_pkg::CH_W-1:0] rb, gb, bb;

  always_comb begin
    rb = red_k;
    gb = green_k;
    bb = blue_k;
    if (side.mark) begin
      rb = '0;
      gb = apr_pkg::FULL_BYTE;
      bb = '0;
    end
    if (side.bar) begin
      rb = apr_pkg::FULL_BYTE;
      gb = '0;
      bb = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= in_valid;
    end
    if (adv) begin
      m_tdata <= {6'd0, rb, gb, bb, side.offset};
      m_tuser <= side.fin;
    end
  end

endmodule
`default_nettype wire

### rtl/accumulated_pixel_resolve_gamma2.sv
// Top level: pixel resolve with averaging, gamma 2 root, progress bar.
//
//  channel | dir | tdata (low bit up)                          | tuser
//  s_*     | in  | column 12, row 12, red 32, green 32, blue 32 | is_finalized, newly_finalized
//  m_*     | out | byte_offset 26, blue 8, green 8, red 8, pad 6 | clear_newly_finalized
//  cfg_*   | in  | index 3, data 16 (write only)                |
//
// One pixel per cycle while the output is not stalled; the path is an input stage, the lane pipeline
// (one scale multiply stage plus eight root-search stages, one result bit each),
// and the output register.
// Reset clears valid bits and configuration registers; nothing else needs clearing.
// A stalled output beat holds the whole pipeline; tready follows that stall.
`default_nettype none
module accumulated_pixel_resolve_gamma2 #(
  parameter int ACC_FRAC_BITS = apr_pkg::ACC_FRAC_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [119:0]              s_tdata,  // col, row, red, green, blue
  input  wire logic [1:0]                s_tuser,  // is_finalized, newly_finalized
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [55:0]                    m_tdata,  // byte_offset, blue, green, red, pad
  output logic [0:0]                     m_tuser,  // clear_newly_finalized
  input  wire logic                      cfg_we,
  input  wire logic [apr_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [15:0]               cfg_data
);

  localparam int LAT = apr_pkg::STEPS + 1;

  // configuration registers
  logic                        cfg_inter;
  logic [apr_pkg::PASS_W-1:0]  cfg_passes;
  logic                        cfg_prog_en;
  logic [apr_pkg::CFG_W-1:0]   cfg_prog_cols;
  logic [apr_pkg::CFG_W-1:0]   cfg_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_inter     <= 1'b0;
      cfg_passes    <= '0;
      cfg_prog_en   <= 1'b0;
      cfg_prog_cols <= '0;
      cfg_width     <= apr_pkg::RESET_WIDTH;
    end else if (cfg_we) begin
      case (cfg_index)
        apr_pkg::REG_INTERACTIVE: cfg_inter     <= cfg_data[0];
        apr_pkg::REG_PASSES:      cfg_passes    <= cfg_data;
        apr_pkg::REG_PROG_EN:     cfg_prog_en   <= cfg_data[0];
        apr_pkg::REG_PROG_COLS:   cfg_prog_cols <= cfg_data[apr_pkg::CFG_W-1:0];
        apr_pkg::REG_WIDTH:       cfg_width     <= cfg_data[apr_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves when the output slot is free or being drained
  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  logic [apr_pkg::COORD_W-1:0] in_col, in_row;
  logic                        in_fin, in_fresh;
  assign in_col   = s_tdata[11:0];
  assign in_row   = s_tdata[23:12];
  assign in_fin   = s_tuser[0];
  assign in_fresh = s_tuser[1];

  // input stage
  logic [apr_pkg::COORD_W-1:0] col0;
  logic [apr_pkg::PROD_W-1:0]  prod0;
  logic                        fin0, mark0, bar0;
  logic [apr_pkg::DIV_W-1:0]   div0, div_sel;
  logic [apr_pkg::SUM_W-1:0]   red0, green0, blue0;

  always_comb begin
    if (!in_fin) begin
      div_sel = apr_pkg::DIV_W'(cfg_passes) + apr_pkg::UNIT_DIVISOR;
    end else if (cfg_inter) begin
      div_sel = apr_pkg::UNIT_DIVISOR;
    end else begin
      div_sel = apr_pkg::FINAL_DIVISOR;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      col0   <= in_col;
      prod0  <= apr_pkg::PROD_W'(cfg_width) * apr_pkg::PROD_W'(in_row);
      fin0   <= in_fin;
      mark0  <= in_fin && in_fresh && !cfg_inter;
      bar0   <= cfg_prog_en && (in_row < apr_pkg::BAR_ROWS) &&
                (apr_pkg::CFG_W'(in_col) < cfg_prog_cols);
      div0   <= div_sel;
      red0   <= s_tdata[55:24];
      green0 <= s_tdata[87:56];
      blue0  <= s_tdata[119:88];
    end
  end

  // valid bits and sideband that ride alongside the lanes
  logic           vld  [LAT+1];
  apr_pkg::side_t side [1:LAT];
  logic [apr_pkg::OFF_W-1:0] pix_index;
  assign pix_index = apr_pkg::OFF_W'(prod0) + apr_pkg::OFF_W'(col0);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= LAT; i++) vld[i] <= 1'b0;
    end else if (adv) begin
      vld[0] <= s_tvalid;
      for (int i = 1; i <= LAT; i++) vld[i] <= vld[i-1];
    end
    if (adv) begin
      side[1].offset <= {pix_index[apr_pkg::OFF_W-3:0], 2'b00};
      side[1].fin    <= fin0;
      side[1].mark   <= mark0;
      side[1].bar    <= bar0;
      for (int i = 2; i <= LAT; i++) side[i] <= side[i-1];
    end
  end

  logic [apr_pkg::CH_W-1:0] red_k, green_k, blue_k;

  apr_lane #(.ACC_FRAC_BITS(ACC_FRAC_BITS)) u_red (
    .clk(clk), .en(adv), .sum(red0), .div(div0), .kout(red_k)
  );
  apr_lane #(.ACC_FRAC_BITS(ACC_FRAC_BITS)) u_green (
    .clk(clk), .en(adv), .sum(green0), .div(div0), .kout(green_k)
  );
  apr_lane #(.ACC_FRAC_BITS(ACC_FRAC_BITS)) u_blue (
    .clk(clk), .en(adv), .sum(blue0), .div(div0), .kout(blue_k)
  );

  apr_merge u_merge (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(vld[LAT]), .side(side[LAT]),
    .red_k(red_k), .green_k(green_k), .blue_k(blue_k),
    .m_tvalid(m_tvalid), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

`ifndef SYNTH
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");
  a_bar_red: assert property (@(posedge clk) disable iff (rst)
    (adv && vld[LAT] && side[LAT].bar) |=>
      (m_tdata[49:42] == apr_pkg::FULL_BYTE && m_tdata[41:26] == 16'd0))
    else $error("progress bar pixel not red");
  a_mark_green: assert property (@(posedge clk) disable iff (rst)
    (adv && vld[LAT] && side[LAT].mark && !side[LAT].bar) |=>
      (m_tdata[41:34] == apr_pkg::FULL_BYTE && m_tdata[49:42] == 8'd0 &&
       m_tdata[33:26] == 8'd0))
    else $error("finalize marking not green");
`endif

endmodule
`default_nettype wire

### tb/accumulated_pixel_resolve_gamma2_test.sv
// Testbench for the pixel resolve block: directed table, random pixels, scoreboard.
`default_nettype none
module accumulated_pixel_resolve_gamma2_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 11;
  localparam int N_RANDOM = 1330;

  // one pixel beat as it enters
  typedef struct {
    logic [11:0] col;
    logic [11:0] row;
    logic [31:0] red;
    logic [31:0] green;
    logic [31:0] blue;
    logic        fin;
    logic        fresh;
  } pixel_t;

  // one resolved beat as it leaves
  typedef struct packed {
    logic [25:0] offset;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic        clear;
  } shade_t;

  // directed row: pixel plus an optional hand-typed answer
  typedef struct {
    pixel_t pix;
    logic   typed;
    shade_t want;
  } vector_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [119:0] s_tdata = '0;  // col 12, row 12, red 32, green 32, blue 32
  logic [1:0] s_tuser = '0;    // is_finalized, newly_finalized
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [55:0] m_tdata;        // byte_offset 26, blue 8, green 8, red 8, pad 6
  logic [0:0] m_tuser;         // clear_newly_finalized
  logic cfg_we = 1'b0;
  logic [apr_pkg::IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  always #1 clk = ~clk;

  accumulated_pixel_resolve_gamma2 i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow of the register file
  logic        interactive;
  logic [15:0] passes;
  logic        bar_on;
  logic [12:0] bar_cols;
  logic [12:0] width;

  shade_t expected_shades[$];
  int mismatches = 0;
  int pixels_sent = 0;
  int shades_seen = 0;
  int send_idle_pct = 0;   // sender gap chance, percent
  int recv_stall_pct = 0;  // receiver stall chance, percent
  int hold_off = 0;        // cycles of forced receiver stall still to run
  int configs_done = 0;

  // largest k <= 255 with k*k*D*2^F <= 65025*v, one bit at a time
  function automatic logic [7:0] tone(input logic [31:0] v, input logic [16:0] d);
    logic [63:0] rhs;
    logic [63:0] scale;
    logic [63:0] t;
    logic [7:0] k;
    rhs = 64'(v) * 64'd65025;
    scale = 64'(d) << apr_pkg::ACC_FRAC_BITS;
    k = '0;
    for (int b = 7; b >= 0; b--) begin
      t = 64'(k | (8'd1 << b));
      if (t * t * scale <= rhs) k = k | (8'd1 << b);
    end
    return k;
  endfunction

  function automatic shade_t resolve(input pixel_t p);
    shade_t s;
    logic [16:0] d;
    logic [37:0] lin;
    if (p.fin && p.fresh && !interactive) begin
      s.red = 8'd0; s.green = apr_pkg::FULL_BYTE; s.blue = 8'd0;
    end else begin
      if (!p.fin) d = 17'(passes) + 17'd1;
      else d = interactive ? apr_pkg::UNIT_DIVISOR : apr_pkg::FINAL_DIVISOR;
      s.red = tone(p.red, d);
      s.green = tone(p.green, d);
      s.blue = tone(p.blue, d);
    end
    if (bar_on && p.row < apr_pkg::BAR_ROWS && 13'(p.col) < bar_cols) begin
      s.red = apr_pkg::FULL_BYTE; s.green = 8'd0; s.blue = 8'd0;
    end
    lin = 38'(p.col) + 38'(width) * 38'(p.row);
    s.offset = 26'(lin << 2);
    s.clear = p.fin;
    return s;
  endfunction

  // one write, then a wait with the enable low so the enable never flips twice in one step
  task automatic write_reg(input logic [apr_pkg::IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      apr_pkg::REG_INTERACTIVE: interactive = val[0];
      apr_pkg::REG_PASSES:      passes = val;
      apr_pkg::REG_PROG_EN:     bar_on = val[0];
      apr_pkg::REG_PROG_COLS:   bar_cols = val[12:0];
      apr_pkg::REG_WIDTH:       width = val[12:0];
      default: ;
    endcase
    configs_done++;
    @(posedge clk);
  endtask

  task automatic setup(input logic i, input logic [15:0] p, input logic b,
                       input logic [12:0] c, input logic [12:0] w);
    write_reg(apr_pkg::REG_INTERACTIVE, 16'(i));
    write_reg(apr_pkg::REG_PASSES, p);
    write_reg(apr_pkg::REG_PROG_EN, 16'(b));
    write_reg(apr_pkg::REG_PROG_COLS, 16'(c));
    write_reg(apr_pkg::REG_WIDTH, 16'(w));
  endtask

  // offer one pixel, honoring the sender idle rate, until accepted;
  // valid stays up so the next beat can follow with no gap
  task automatic send_pixel(input pixel_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {p.blue, p.green, p.red, p.row, p.col};
    s_tuser <= {p.fresh, p.fin};
    expected_shades.push_back(resolve(p));
    pixels_sent++;
    do @(posedge clk); while (!s_tready);
  endtask

  // block is idle: queue empty plus pipeline drain time
  task automatic drain;
    s_tvalid <= 1'b0;
    while (expected_shades.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_sum;
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(32'h3_FFFF);  // dim values where roots differ finely
      3: return $urandom_range(32'h40_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic pixel_t rand_pixel;
    pixel_t p;
    p.col = ($urandom_range(3) == 0) ? 12'($urandom_range(7)) : 12'($urandom);
    p.row = ($urandom_range(2) == 0) ? 12'($urandom_range(4)) : 12'($urandom);
    p.red = rand_sum();
    p.green = rand_sum();
    p.blue = rand_sum();
    p.fin = 1'($urandom_range(1));
    p.fresh = 1'($urandom_range(1));
    return p;
  endfunction

  // receiver: random stalls, plus a forced hold-off counted here
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_off > 0) begin
      m_tready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // scoreboard: compare each beat with the oldest prediction
  always @(posedge clk) begin
    shade_t got;
    shade_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[25:0], m_tdata[33:26], m_tdata[41:34], m_tdata[49:42], m_tuser[0]};
      shades_seen++;
      if (expected_shades.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", got);
      end else begin
        want = expected_shades.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"beat %0d: want off %h b %h g %h r %h clr %b, ",
                      "got off %h b %h g %h r %h clr %b"},
                     shades_seen, want.offset, want.blue, want.green, want.red, want.clear,
                     got.offset, got.blue, got.green, got.red, got.clear);
        end
      end
    end
  end

  // directed table: extremes, each divisor path, marking, bar edges
  vector_t table_rows[] = '{
    // zero sums give black, offset zero
    '{'{12'd0, 12'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0}, 1'b1,
      '{26'd0, 8'd0, 8'd0, 8'd0, 1'b0}},
    // full sums saturate at 255
    '{'{12'd1, 12'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0}, 1'b1,
      '{26'd4, 8'd255, 8'd255, 8'd255, 1'b0}},
    // just finalized, not interactive: pure green, clear flag
    '{'{12'd2, 12'd1, 32'h1234, 32'h0, 32'hFFFF, 1'b1, 1'b1}, 1'b1,
      '{26'd2568, 8'd0, 8'd255, 8'd0, 1'b1}},
    // exactly 1.0 at divisor 1 reaches 255
    '{'{12'd0, 12'd0, 32'h1_0000, 32'h0_FFFF, 32'h0, 1'b0, 1'b0}, 1'b1,
      '{26'd0, 8'd0, 8'd254, 8'd255, 1'b0}},
    '{'{12'd4095, 12'd4095, 32'h4_0000, 32'h3_FFFF, 32'h1, 1'b1, 1'b0}, 1'b0, '{default: '0}},
    '{'{12'd4095, 12'd0, 32'h8000, 32'h4000, 32'h100, 1'b0, 1'b1}, 1'b0, '{default: '0}},
    '{'{12'd0, 12'd4095, 32'hABCD_1234, 32'h5555_AAAA, 32'hAAAA_5555, 1'b1, 1'b0},
      1'b0, '{default: '0}}
  };

  initial begin
    #2_000_000;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    pixel_t p;
    interactive = 1'b0; passes = '0; bar_on = 1'b0; bar_cols = '0;
    width = apr_pkg::RESET_WIDTH;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset register values, no idling
    foreach (table_rows[i]) begin
      if (table_rows[i].typed && resolve(table_rows[i].pix) !== table_rows[i].want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("directed row %0d: hand value disagrees with prediction", i);
      end
      send_pixel(table_rows[i].pix);
    end
    drain();

    // interactive and bar settings, the table again
    setup(1'b1, 16'hFFFF, 1'b1, 13'd4096, 13'd4096);
    foreach (table_rows[i]) send_pixel(table_rows[i].pix);
    drain();
    setup(1'b0, 16'd0, 1'b1, 13'd2, 13'd1);
    for (int c = 0; c < 4; c++) begin
      p = table_rows[1].pix; p.col = 12'(c); p.row = 12'(c);
      send_pixel(p);
    end
    send_pixel(table_rows[2].pix);
    drain();
    // unknown register index is ignored
    write_reg(3'd7, 16'hFFFF);

    // random phases with varied settings and idling
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      case (ph)
        0: setup(1'b0, 16'd0, 1'b0, 13'd0, 13'd640);
        1: setup(1'b1, 16'd3, 1'b1, 13'd100, 13'd0);
        2: setup(1'b0, 16'hFFFF, 1'b1, 13'd4096, 13'd4096);
        3: setup(1'b1, 16'd1, 1'b0, 13'd8191, 13'd8191);
        default: setup(1'($urandom_range(1)), 16'($urandom), 1'($urandom_range(1)),
                       13'($urandom_range(4096)), 13'($urandom_range(1, 4096)));
      endcase
      if (ph == 2) hold_off <= 300;  // sender keeps offering while output is held
      for (int n = 0; n < N_RANDOM / 8; n++) begin
        send_pixel(rand_pixel());
        if (n == 80) drain();  // sender pauses until all results are back
      end
      drain();
    end

    $display("sent %0d pixels, checked %0d beats over %0d register writes",
             pixels_sent, shades_seen, configs_done);
    $display("covered all divisor paths, green marking, progress bar and wide offsets");
    if (mismatches == 0 && expected_shades.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d missing", mismatches, expected_shades.size());
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
